// ===== hdl/krt_pkg.sv =====
// Shared types and codes for the keyed record table.
// Holds command and status codes and the request, result and operation structs.
// No dependencies.
package krt_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam int HELD_W = 7;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] key;
      logic [63:0]        name_word;
      logic [13:0]        marks_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [63:0]       result_name;
      logic [13:0]       result_marks;
      logic [HELD_W-1:0] entries_held;
   } rsp_type;

   // decoded request, as queued between the front and the engine
   typedef struct packed {
      logic               is_add;
      logic               is_search;
      logic               is_update;
      logic               is_delete;
      logic signed [31:0] key;
      logic [63:0]        name_word;
      logic [13:0]        marks_value;
   } op_type;

endpackage

// ===== hdl/krt_queue.sv =====
// Small first-in first-out queue of fixed-width words.
// Used for the decoded-request queue and the result queue.
// No package dependencies.
module krt_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/krt_front.sv =====
// Request front end: decodes each command and queues it for the engine.
// Depends on krt_pkg and krt_queue.
module krt_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  krt_pkg::req_type req_data,
   input  logic            op_pop,
   output logic            op_empty,
   output krt_pkg::op_type op_data
);

   krt_pkg::op_type            op_dec;
   logic [$bits(krt_pkg::op_type)-1:0] op_word;

   always_comb begin
      op_dec             = '0;
      op_dec.key         = req_data.key;
      op_dec.name_word   = req_data.name_word;
      op_dec.marks_value = req_data.marks_value;
      case (req_data.command)
         krt_pkg::CMD_ADD:    op_dec.is_add    = 1'b1;
         krt_pkg::CMD_SEARCH: op_dec.is_search = 1'b1;
         krt_pkg::CMD_UPDATE: op_dec.is_update = 1'b1;
         krt_pkg::CMD_DELETE: op_dec.is_delete = 1'b1;
         default:             op_dec.is_add    = 1'b1;
      endcase
   end

   krt_queue #(
      .WIDTH ($bits(krt_pkg::op_type)),
      .DEPTH (2)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (op_dec),
      .full  (full),
      .pop   (op_pop),
      .rdata (op_word),
      .empty (op_empty)
   );

   assign op_data = krt_pkg::op_type'(op_word);

endmodule

// ===== hdl/krt_engine.sv =====
// Record engine: holds the table memory and the fill count, scans for keys,
// updates entries and closes gaps on delete. Depends on krt_pkg.
module krt_engine #(
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_empty,
   input  krt_pkg::op_type  op_data,
   output logic             op_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output krt_pkg::rsp_type rsp_data
);

   localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int CW1 = CW + 1;
   localparam int XW  = (CW > krt_pkg::HELD_W) ? CW : krt_pkg::HELD_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_RESULT = 2'd3;

   typedef struct packed {
      logic [31:0] key;
      logic [63:0] name_word;
      logic [13:0] marks_value;
   } entry_type;

   entry_type       mem [ENTRIES];
   entry_type       rd_data_ff;
   entry_type       wr_data;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic            wr_en;

   logic [1:0]       state_ff, state_in;
   krt_pkg::op_type  op_ff, op_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    fill_ff, fill_in;
   krt_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW1-1:0] next1, next2, fill_x;
   logic           match, more1, more2;
   logic [XW-1:0]  fill_wide;

   assign fill_x    = CW1'(fill_ff);
   assign next1     = CW1'(idx_ff) + CW1'(1);
   assign next2     = CW1'(idx_ff) + CW1'(2);
   assign more1     = (next1 < fill_x);
   assign more2     = (next2 < fill_x);
   assign match     = (rd_data_ff.key == op_ff.key);
   assign fill_wide = XW'(fill_ff);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      rsp_in   = rsp_ff;
      op_pop   = 1'b0;
      rsp_push = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rd_data_ff;
      rsp_data = rsp_ff;
      rsp_data.entries_held = fill_wide[krt_pkg::HELD_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (!op_empty) begin
               op_pop   = 1'b1;
               op_in    = op_data;
               rsp_in   = '0;
               idx_in   = '0;
               state_in = S_RESULT;
               if (op_data.is_add) begin
                  if (fill_ff == CW'(ENTRIES)) begin
                     rsp_in.status = krt_pkg::ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = fill_ff[AW-1:0];
                     wr_data = '{key: op_data.key, name_word: op_data.name_word,
                                 marks_value: op_data.marks_value};
                     fill_in = fill_ff + CW'(1);
                  end
               end else if (fill_ff == '0) begin
                  rsp_in.status = krt_pkg::ST_MISSING;
               end else begin
                  // entry 0 arrives from the memory on the next cycle
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (match) begin
               state_in = S_RESULT;
               if (op_ff.is_search) begin
                  rsp_in.result_name  = rd_data_ff.name_word;
                  rsp_in.result_marks = rd_data_ff.marks_value;
               end else if (op_ff.is_update) begin
                  wr_en               = 1'b1;
                  wr_data.name_word   = op_ff.name_word;
                  wr_data.marks_value = op_ff.marks_value;
               end else if (more1) begin
                  // hold idx as the gap; fetch the entry above it
                  rd_addr  = next1[AW-1:0];
                  state_in = S_SHIFT;
               end else begin
                  fill_in = fill_ff - CW'(1);
               end
            end else if (more1) begin
               rd_addr = next1[AW-1:0];
               idx_in  = next1[AW-1:0];
            end else begin
               rsp_in.status = krt_pkg::ST_MISSING;
               state_in      = S_RESULT;
            end
         end
         S_SHIFT: begin
            // move the fetched entry down into the gap
            wr_en = 1'b1;
            if (more2) begin
               rd_addr = next2[AW-1:0];
               idx_in  = next1[AW-1:0];
            end else begin
               fill_in  = fill_ff - CW'(1);
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== hdl/keyed_record_table_unit.sv =====
// Keyed record table: top level joining the request front end, the record
// engine and the result queue. Depends on krt_pkg, krt_front, krt_engine, krt_queue.
//
// Usage:
//   Requests enter through push/full/req_data; a request is taken on a rising
//   edge with push high and full low. Results leave through empty/pop/rsp_data;
//   the oldest result is shown while empty is low and is taken when pop is high.
//   Every request yields exactly one result, in request order.
// Operation (one request at a time in the engine, one table memory port pair):
//   an add, an add on a full table, or any lookup on an empty table goes straight
//   from idle to the result state. search/update: the scan reads entries from
//   position zero up to the first match, or up to the fill count on a miss. delete:
//   the scan runs to the match and the shift moves each entry above it down by one.
//   The engine takes no new request until the result of the last one is queued.
// Reset: synchronous; both queues empty and the fill count returns to zero.
//   Table contents are not cleared; entries at or above the fill count are unused.
// Stall: the result queue holds two results; past that the engine holds its
//   result, then the two-deep request queue fills and full rises.
module keyed_record_table_unit #(
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  krt_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output krt_pkg::rsp_type rsp_data
);

   localparam logic [krt_pkg::HELD_W-1:0] HELD_MAX = krt_pkg::HELD_W'(ENTRIES);

   logic             op_pop, op_empty;
   krt_pkg::op_type  op_data;
   logic             rsp_push, rsp_full;
   krt_pkg::rsp_type rsp_entry;
   logic [$bits(krt_pkg::rsp_type)-1:0] rsp_word;

   krt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .op_pop   (op_pop),
      .op_empty (op_empty),
      .op_data  (op_data)
   );

   krt_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .op_empty (op_empty),
      .op_data  (op_data),
      .op_pop   (op_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_data (rsp_entry)
   );

   krt_queue #(
      .WIDTH ($bits(krt_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_entry),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_word),
      .empty (empty)
   );

   assign rsp_data = krt_pkg::rsp_type'(rsp_word);

`ifndef SYNTHESIS
   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_entry.status == krt_pkg::ST_FULL) |->
         (rsp_entry.entries_held == HELD_MAX))
      else $error("table-full result with fill count below capacity");

   a_payload_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_entry.status != krt_pkg::ST_DONE) |->
         (rsp_entry.result_name == '0 && rsp_entry.result_marks == '0))
      else $error("failed request carries a payload");

   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (empty && !full))
      else $error("queues not cleared by reset");
`endif

endmodule

// ===== verif/keyed_record_table_unit_test.sv =====
// Testbench for keyed_record_table_unit: directed and random add/search/update/delete requests
// are scored against a shadow copy of the record table kept in a small class.
// Depends on krt_pkg and the keyed_record_table_unit RTL.
module keyed_record_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int RANDOM_REQUESTS = 700;

   typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_type;
   typedef enum {SINK_EAGER, SINK_COIN, SINK_SLOW, SINK_PULSED} sink_mode_type;

   class record_table_shadow_type;
      logic signed [31:0] keys [TABLE_DEPTH];
      logic [63:0]        names [TABLE_DEPTH];
      logic [13:0]        marks [TABLE_DEPTH];
      int                 held;
      int                 mismatches;
      krt_pkg::rsp_type   replies_owed [$];

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return replies_owed.size();
      endfunction

      function logic signed [31:0] any_held_key();
         return keys[$urandom_range(0, held - 1)];
      endfunction

      // Apply one accepted request to the shadow table and queue the reply it must produce.
      function void apply_command(krt_pkg::req_type r);
         krt_pkg::rsp_type reply;
         int hit;
         int i;
         reply = '0;
         reply.status = krt_pkg::ST_DONE;
         if (r.command == krt_pkg::CMD_ADD) begin
            if (held >= TABLE_DEPTH) begin
               reply.status = krt_pkg::ST_FULL;
            end else begin
               keys[held] = r.key;
               names[held] = r.name_word;
               marks[held] = r.marks_value;
               held++;
            end
         end else begin
            hit = -1;
            for (i = 0; i < held; i++) begin
               if (hit < 0 && keys[i] == r.key) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               reply.status = krt_pkg::ST_MISSING;
            end else if (r.command == krt_pkg::CMD_SEARCH) begin
               reply.result_name = names[hit];
               reply.result_marks = marks[hit];
            end else if (r.command == krt_pkg::CMD_UPDATE) begin
               names[hit] = r.name_word;
               marks[hit] = r.marks_value;
            end else begin
               // close the gap left by the deleted record
               for (i = hit; i + 1 < held; i++) begin
                  keys[i] = keys[i + 1];
                  names[i] = names[i + 1];
                  marks[i] = marks[i + 1];
               end
               held--;
            end
         end
         reply.entries_held = held[krt_pkg::HELD_W-1:0];
         replies_owed.push_back(reply);
      endfunction

      function void compare_reply(krt_pkg::rsp_type got);
         krt_pkg::rsp_type want;
         if (replies_owed.size() == 0) begin
            $error("unexpected result: status %0d, entries_held %0d", got.status,
                   got.entries_held);
            mismatches++;
            return;
         end
         want = replies_owed.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.result_name !== want.result_name) begin
            $error("result_name: expected %h, actual %h", want.result_name, got.result_name);
            mismatches++;
         end
         if (got.result_marks !== want.result_marks) begin
            $error("result_marks: expected %0d, actual %0d", want.result_marks,
                   got.result_marks);
            mismatches++;
         end
         if (got.entries_held !== want.entries_held) begin
            $error("entries_held: expected %0d, actual %0d", want.entries_held,
                   got.entries_held);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             full;
   krt_pkg::req_type req_data = '0;
   logic             empty;
   logic             pop = 1'b0;
   krt_pkg::rsp_type rsp_data;

   record_table_shadow_type shadow = new();
   int burst_left = 1;
   int replies_taken = 0;

   keyed_record_table_unit #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // Offer one request, hold it until taken, then maybe start an idle gap.
   task automatic send_request(logic [1:0] cmd, logic signed [31:0] key, logic [63:0] name,
                               logic [13:0] mark);
      krt_pkg::req_type r;
      int gap;
      r.command = cmd;
      r.key = key;
      r.name_word = name;
      r.marks_value = mark;
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      shadow.apply_command(r);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : request_source
      mix_type mix;
      int round_left;
      int n;
      int pick;
      logic [1:0] cmd;
      logic signed [31:0] key;
      logic [13:0] mark;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // lookups on an empty table
      send_request(krt_pkg::CMD_SEARCH, 32'sd5, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_UPDATE, 32'sd5, 64'h1111_2222_3333_4444, 14'd100);
      send_request(krt_pkg::CMD_DELETE, 32'sd5, 64'h0, 14'd0);
      // key and payload extremes, mark above the nominal range, duplicate key
      send_request(krt_pkg::CMD_ADD, 32'sh8000_0000, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_ADD, 32'sh7fff_ffff, 64'hffff_ffff_ffff_ffff, 14'd10000);
      send_request(krt_pkg::CMD_ADD, -32'sd1, 64'h0123_4567_89ab_cdef, 14'd16383);
      send_request(krt_pkg::CMD_ADD, 32'sd0, 64'ha5a5_5a5a_f00d_cafe, 14'd1);
      send_request(krt_pkg::CMD_ADD, -32'sd1, 64'hdead_beef_0000_0001, 14'd7);
      send_request(krt_pkg::CMD_SEARCH, -32'sd1, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_SEARCH, 32'sh8000_0000, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_SEARCH, 32'sh7fff_ffff, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_SEARCH, 32'sd12345, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_UPDATE, -32'sd1, 64'hfeed_face_1234_5678, 14'd9999);
      send_request(krt_pkg::CMD_SEARCH, -32'sd1, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_DELETE, 32'sh8000_0000, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_SEARCH, 32'sd0, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_DELETE, -32'sd1, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_SEARCH, -32'sd1, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_DELETE, -32'sd1, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_DELETE, 32'sd777, 64'h0, 14'd0);
      send_request(krt_pkg::CMD_UPDATE, 32'sd777, 64'hffff_0000_ffff_0000, 14'd3);
      send_request(krt_pkg::CMD_SEARCH, 32'sh7fff_ffff, 64'h0, 14'd0);

      // open with a long fill round so the table overflows early
      mix = MIX_FILL;
      round_left = 150;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (round_left == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            round_left = $urandom_range(30, 90);
         end
         round_left--;

         pick = $urandom_range(0, 99);
         case (mix)
            MIX_FILL: begin
               if (pick < 85) cmd = krt_pkg::CMD_ADD;
               else if (pick < 92) cmd = krt_pkg::CMD_SEARCH;
               else if (pick < 96) cmd = krt_pkg::CMD_UPDATE;
               else cmd = krt_pkg::CMD_DELETE;
            end
            MIX_CHURN: begin
               if (pick < 25) cmd = krt_pkg::CMD_ADD;
               else if (pick < 50) cmd = krt_pkg::CMD_SEARCH;
               else if (pick < 75) cmd = krt_pkg::CMD_UPDATE;
               else cmd = krt_pkg::CMD_DELETE;
            end
            default: begin
               if (pick < 10) cmd = krt_pkg::CMD_ADD;
               else if (pick < 25) cmd = krt_pkg::CMD_SEARCH;
               else if (pick < 35) cmd = krt_pkg::CMD_UPDATE;
               else cmd = krt_pkg::CMD_DELETE;
            end
         endcase

         // lookups mostly use held keys, adds mostly random ones; a small pool forces duplicates
         pick = $urandom_range(0, 99);
         if (cmd == krt_pkg::CMD_ADD) begin
            if (pick < 60) key = $urandom;
            else if (pick < 85 || shadow.held == 0) key = $urandom_range(0, 15) - 8;
            else key = shadow.any_held_key();
         end else begin
            if (pick < 75 && shadow.held > 0) key = shadow.any_held_key();
            else if (pick < 85) key = $urandom_range(0, 15) - 8;
            else key = $urandom;
         end

         mark = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                            : 14'($urandom_range(0, 10000));
         send_request(cmd, key, {$urandom, $urandom}, mark);

         if (n == 400) begin
            // hold off until the block has drained
            push <= 1'b0;
            while (shadow.outstanding() != 0) @(posedge clock);
         end
      end

      push <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : reply_sink
      sink_mode_type mode;
      int cycles_in_mode;
      bit long_hold_done;
      mode = SINK_EAGER;
      cycles_in_mode = 0;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            shadow.compare_reply(rsp_data);
            replies_taken++;
         end
         if (!long_hold_done && replies_taken >= 150) begin
            // stall long enough for the request side to back up and raise full
            long_hold_done = 1'b1;
            pop <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            if (cycles_in_mode == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               cycles_in_mode = $urandom_range(20, 80);
            end
            cycles_in_mode--;
            case (mode)
               SINK_EAGER: pop <= 1'b1;
               SINK_COIN:  pop <= 1'($urandom_range(0, 1));
               SINK_SLOW:  pop <= ($urandom_range(0, 4) == 0);
               default:    pop <= ((cycles_in_mode % 8) < 2);
            endcase
         end
      end
   end

   initial begin : run_limit
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
